// File: design/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared widths, operation codes and controller command type for the
// LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  // fixed field widths
  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned CAP_W = 5;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried on kind_i
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming operation
    logic lookup;  // key search, victim select, data read
    logic commit;  // apply the update and register the result
  } ctrl_cmd_t;

endpackage

// File: design/lfuc_ram.sv
// ----------------------------------------------------------------------------
// lfuc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfuc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/lfuc_ctrl.sv
// ----------------------------------------------------------------------------
// lfuc_ctrl
// Operation sequencer: accept, lookup cycle, update cycle.
// ----------------------------------------------------------------------------
module lfuc_ctrl
  import lfuc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // a new beat may enter while the update cycle runs
  assign busy   = (state_q == ST_LOOK);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.load   = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.commit = 1'b1;
        state_d      = accept ? ST_LOOK : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/lfuc_dp.sv
// ----------------------------------------------------------------------------
// lfuc_dp
// Entry lanes (valid, key, use count, recency rank), parallel key match,
// registered victim tree, value RAM and result registers.
// ----------------------------------------------------------------------------
module lfuc_dp
  import lfuc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             kind_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] read_value_o,
  output logic             evicted_o,
  output logic [KEY_W-1:0] evicted_key_o
);

  localparam int unsigned IDXW  = $clog2(ENTRIES);
  localparam int unsigned FILLW = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW  = (FILLW > CAP_W) ? FILLW : CAP_W;
  localparam int unsigned N2    = 1 << IDXW;
  localparam int unsigned NODES = 2 * N2 - 1;
  localparam int unsigned SELW  = COUNT_BITS + IDXW;

  // configuration
  logic [CAP_W-1:0] cap_q;

  // captured operation
  logic             op_kind_q;
  logic [KEY_W-1:0] op_key_q;
  logic [VAL_W-1:0] op_val_q;

  // entry lanes
  logic [ENTRIES-1:0]    vld_q, vld_d;
  logic [KEY_W-1:0]      ent_key_q  [ENTRIES];
  logic [KEY_W-1:0]      ent_key_d  [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_q      [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_d      [ENTRIES];
  logic [IDXW-1:0]       rank_q     [ENTRIES];
  logic [IDXW-1:0]       rank_d     [ENTRIES];
  logic [FILLW-1:0]      fill_q, fill_d;

  // lookup results
  logic            hit_any, free_ok;
  logic [IDXW-1:0] hit_idx, hit_rank, free_idx;
  logic            hit_q, free_ok_q;
  logic [IDXW-1:0] hit_idx_q, hit_rank_q, free_idx_q, vic_idx_q, vic_rank_q;
  logic [KEY_W-1:0] vic_key_q;

  // victim tree nodes
  logic [NODES-1:0] nd_vld;
  logic [SELW-1:0]  nd_sel [NODES];
  logic [IDXW-1:0]  nd_idx [NODES];
  logic [KEY_W-1:0] nd_key [NODES];

  // update controls
  logic [CMPW-1:0]  cap_eff, fill_ext;
  logic             is_put, cap_zero, full;
  logic             do_bump, do_ins, do_evict;
  logic [IDXW-1:0]  slot;
  logic             ram_we;
  logic [IDXW-1:0]  ram_waddr;
  logic [VAL_W-1:0] ram_rdata;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // operation capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_kind_q <= kind_i;
      op_key_q  <= key_i;
      op_val_q  <= value_i;
    end
  end

  // parallel key match and first free lane
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    hit_rank = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (vld_q[i] && (ent_key_q[i] == op_key_q)) begin
        hit_any  = 1'b1;
        hit_idx  = hit_idx | IDXW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  // victim tree: lowest count, then oldest (inverted rank as low bits)
  for (genvar g = 0; g < N2; g++) begin : g_leaf
    if (g < ENTRIES) begin : g_real
      assign nd_vld[N2-1+g] = vld_q[g];
      assign nd_sel[N2-1+g] = {cnt_q[g], ~rank_q[g]};
      assign nd_idx[N2-1+g] = IDXW'(g);
      assign nd_key[N2-1+g] = ent_key_q[g];
    end else begin : g_pad
      assign nd_vld[N2-1+g] = 1'b0;
      assign nd_sel[N2-1+g] = '0;
      assign nd_idx[N2-1+g] = '0;
      assign nd_key[N2-1+g] = '0;
    end
  end

  for (genvar j = 0; j < N2 - 1; j++) begin : g_node
    logic pick_l;
    assign pick_l    = nd_vld[2*j+1] &&
                       (!nd_vld[2*j+2] || (nd_sel[2*j+1] <= nd_sel[2*j+2]));
    assign nd_vld[j] = nd_vld[2*j+1] | nd_vld[2*j+2];
    assign nd_sel[j] = pick_l ? nd_sel[2*j+1] : nd_sel[2*j+2];
    assign nd_idx[j] = pick_l ? nd_idx[2*j+1] : nd_idx[2*j+2];
    assign nd_key[j] = pick_l ? nd_key[2*j+1] : nd_key[2*j+2];
  end

  // lookup registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q      <= hit_any;
      hit_idx_q  <= hit_idx;
      hit_rank_q <= hit_rank;
      free_ok_q  <= free_ok;
      free_idx_q <= free_idx;
      vic_idx_q  <= nd_idx[0];
      vic_rank_q <= ~nd_sel[0][IDXW-1:0];
      vic_key_q  <= nd_key[0];
    end
  end

  // decode of the update
  assign cap_eff  = (CMPW'(cap_q) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(cap_q);
  assign fill_ext = CMPW'(fill_q);
  assign is_put   = (op_kind_q == KIND_PUT);
  assign cap_zero = (cap_q == '0);
  assign full     = (fill_ext >= cap_eff);
  assign do_bump  = hit_q && (!is_put || !cap_zero);
  assign do_ins   = is_put && !hit_q && !cap_zero;
  assign do_evict = do_ins && full;
  assign slot     = (do_evict && !(free_ok_q && (free_idx_q < vic_idx_q))) ?
                    vic_idx_q : free_idx_q;

  // lane next state
  always_comb begin
    vld_d  = vld_q;
    fill_d = fill_q;
    for (int i = 0; i < ENTRIES; i++) begin
      ent_key_d[i] = ent_key_q[i];
      cnt_d[i]     = cnt_q[i];
      rank_d[i]    = rank_q[i];
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_bump) begin
          if (IDXW'(i) == hit_idx_q) begin
            if (!(&cnt_q[i])) cnt_d[i] = cnt_q[i] + 1'b1;
            rank_d[i] = '0;
          end else if (vld_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        if (do_ins) begin
          if (IDXW'(i) == slot) begin
            vld_d[i]     = 1'b1;
            ent_key_d[i] = op_key_q;
            cnt_d[i]     = COUNT_BITS'(1);
            rank_d[i]    = '0;
          end else if (do_evict && (IDXW'(i) == vic_idx_q)) begin
            vld_d[i] = 1'b0;
          end else if (vld_q[i]) begin
            if (do_evict && (rank_q[i] > vic_rank_q)) begin
              rank_d[i] = rank_q[i];
            end else begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
        end
      end
      if (do_ins && !do_evict) fill_d = fill_q + 1'b1;
    end
  end

  // lane control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      fill_q <= '0;
    end else begin
      vld_q  <= vld_d;
      fill_q <= fill_d;
    end
  end

  // lane payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      ent_key_q[i] <= ent_key_d[i];
      cnt_q[i]     <= cnt_d[i];
      rank_q[i]    <= rank_d[i];
    end
  end

  // value store
  assign ram_we    = cmd_i.commit && is_put && !cap_zero;
  assign ram_waddr = hit_q ? hit_idx_q : slot;

  lfuc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_val_q),
    .re_i    (cmd_i.lookup),
    .raddr_i (hit_idx),
    .rdata_o (ram_rdata)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.commit;
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= hit_q;
      read_value_o  <= (hit_q && (op_kind_q == KIND_GET)) ? ram_rdata : '0;
      evicted_o     <= do_evict;
      evicted_key_o <= do_evict ? vic_key_q : '0;
    end
  end

endmodule

// File: design/lfu_cache_with_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak
// Fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie-break.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind_i (0 get, 1 put), key_i, value_i with start;
//   the beat is taken at a rising edge where start is high and busy is low.
//   Result channel: done_o is high for exactly one cycle with hit_o,
//   read_value_o, evicted_o and evicted_key_o; the receiver cannot stall it.
//   Config: cfg_we_i writes cfg_wdata_i into the capacity register; write it
//   only while no command is in flight.
// Timing:
//   busy is high for one cycle after each accepted command (the lookup
//   cycle: parallel key match, min-count/oldest victim tree, value RAM
//   read). The following update cycle can accept the next command, so a
//   new command can enter before the previous result beat. done_o is
//   registered from the commit of the update cycle, which follows the lookup cycle.
// Reset:
//   rst_ni clears all valid bits and the fill level and sets capacity to 16;
//   the cache can accept a command as soon as reset is released.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak
  import lfuc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             kind_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] read_value_o,
  output logic             evicted_o,
  output logic [KEY_W-1:0] evicted_key_o
);

  ctrl_cmd_t cmd;

  // sequencer
  lfuc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // datapath
  lfuc_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

endmodule

// File: design/lfuc_checker.sv
// ----------------------------------------------------------------------------
// lfuc_checker
// Port-level checks of command sequencing and result consistency.
// ----------------------------------------------------------------------------
module lfuc_checker
  import lfuc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic             hit_o,
  input logic [VAL_W-1:0] read_value_o,
  input logic             evicted_o
);

  // busy covers only the lookup cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |=> !busy)
    else $error("busy held for more than one cycle");

  // every accepted command yields a result beat after its lookup and update cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("missing result beat");

  // no result beat without a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("spurious result beat");

  // an eviction only happens on a miss, and a miss returns no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (read_value_o == '0))
    else $error("value returned on a miss");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> !hit_o)
    else $error("eviction reported on a hit");

endmodule

bind lfu_cache_with_lru_tiebreak lfuc_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .read_value_o (read_value_o),
  .evicted_o    (evicted_o)
);
